// ----- rtl/core/slr_pkg.sv -----
// Shared types, sizes and codes for the slotted bandwidth reservation block.
package slr_pkg;

    // Ring geometry.
    localparam int SLOTS = 128;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Data widths.
    localparam int DATA_W    = 32;
    localparam int SCALE_W   = 16;
    localparam int DIV_W     = 34;
    localparam int CFG_IDX_W = 2;

    // Request kinds.
    localparam logic [1:0] REQ_CHECK   = 2'd0;
    localparam logic [1:0] REQ_RESERVE = 2'd1;
    localparam logic [1:0] REQ_FORCE   = 2'd2;
    localparam logic [1:0] REQ_ADVANCE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_OVER_CAP = 2'd2;
    localparam logic [1:0] ST_BACKWARD = 2'd3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 2'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  start_offset;
        logic [7:0]  duration;
        logic [31:0] amount;
        logic [31:0] new_time;
    } req_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] status;
    } rsp_t;

endpackage

// ----- rtl/core/slotted_bandwidth_reservation.sv -----
// Slotted bandwidth reservation: a circular calendar of reserved load per time slot.
// One request word is processed at a time. Every request that passes the length and
// backward-time checks first runs two serial divisions by the slot scale on one shared
// divider (first slot number, then the end slot number rounded up, or the old and new
// slot numbers for an advance); the ring position is the low bits of the first slot number.
// A check then walks the covered slots through the slot memory at one slot per
// cycle, and a reserve walks them a second time to add the amount; a forced
// reserve walks them once. An advance clears the expired slots one per cycle, or the
// whole ring at once when SLOTS or more slots expire. Request throughput is limited by
// the serial divider and the single read port of the slot memory.
// Slot validity is held in flip-flops, so no memory clearing pass is needed after
// reset. Configuration registers must be written only while no request is in work.
module slotted_bandwidth_reservation
    import slr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsp_t                 out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRE   = 4'd1;
    localparam logic [3:0] S_DIV0  = 4'd2;
    localparam logic [3:0] S_DIV1  = 4'd3;
    localparam logic [3:0] S_CALC  = 4'd5;
    localparam logic [3:0] S_CHECK = 4'd6;
    localparam logic [3:0] S_ADD   = 4'd7;
    localparam logic [3:0] S_CLEAR = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]         state_reg, state_next;
    req_t               req_reg, req_next;
    logic [DATA_W-1:0]  cur_time_reg, cur_time_next;
    logic [DATA_W-1:0]  capacity_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [DIV_W-1:0]   q0_reg, q0_next;
    logic [DIV_W-1:0]   q1_reg, q1_next;
    logic [IDX_W-1:0]   base_reg, base_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               vbit_reg, vbit_next;
    logic               fail_reg, fail_next;
    logic               acc_reg, acc_next;
    logic [1:0]         st_reg, st_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_data_reg, out_data_next;
    logic [SLOTS-1:0]   slot_valid_reg, slot_valid_next;

    logic [SCALE_W-1:0] eff_scale;
    logic [DIV_W-1:0]   start_sum;
    logic [DIV_W-1:0]   end_sum;
    logic [DIV_W-1:0]   ceil_num;
    logic [DIV_W-1:0]   span;
    logic [8:0]         len_sum;
    logic               issue;
    logic [IDX_W-1:0]   idx_inc;
    logic [DATA_W-1:0]  slot_data;
    logic [DATA_W:0]    sum;
    logic [DATA_W-1:0]  sat_sum;

    logic               div_start;
    logic [DIV_W-1:0]   div_dvd;
    logic [SCALE_W-1:0] div_dvs;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;

    logic               ram_we;
    logic [DATA_W-1:0]  ram_rdata;

    slr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo)
    );

    slr_ram #(
        .DEPTH (SLOTS),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (sat_sum),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Interval arithmetic and slot data path.
    always_comb
    begin
        eff_scale = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
        start_sum = DIV_W'(cur_time_reg) + DIV_W'(req_reg.start_offset);
        end_sum   = start_sum + DIV_W'(req_reg.duration);
        ceil_num  = end_sum + DIV_W'(eff_scale) - DIV_W'(1);
        span      = q1_reg - q0_reg;
        len_sum   = 9'(req_reg.start_offset) + 9'(req_reg.duration);
        issue     = k_reg != cnt_reg;
        idx_inc   = (idx_reg == IDX_W'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;
        slot_data = vbit_reg ? ram_rdata : '0;
        sum       = {1'b0, slot_data} + {1'b0, req_reg.amount};
        sat_sum   = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
    end

    // Divider operand selection.
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = start_sum;
        div_dvs   = eff_scale;
        case (state_reg)
            S_PRE:
            begin
                div_dvd = (req_reg.req_type == REQ_ADVANCE) ? DIV_W'(cur_time_reg) : start_sum;
            end
            S_DIV0:
            begin
                div_dvd = (req_reg.req_type == REQ_ADVANCE) ? DIV_W'(req_reg.new_time)
                                                            : ceil_num;
            end
            default:
            begin
                div_dvd = start_sum;
            end
        endcase
        if (state_reg == S_PRE)
        begin
            div_start = !((req_reg.req_type == REQ_ADVANCE &&
                           req_reg.new_time < cur_time_reg) ||
                          ((req_reg.req_type == REQ_CHECK || req_reg.req_type == REQ_RESERVE) &&
                           len_sum > 9'(SLOTS)));
        end
        else if (state_reg == S_DIV0 && div_done)
        begin
            div_start = 1'b1;
        end
    end

    // Request sequencer.
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        cur_time_next   = cur_time_reg;
        q0_next         = q0_reg;
        q1_next         = q1_reg;
        base_next       = base_reg;
        idx_next        = idx_reg;
        wr_idx_next     = wr_idx_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        rd_pend_next    = 1'b0;
        vbit_next       = vbit_reg;
        fail_next       = fail_reg;
        acc_next        = acc_reg;
        st_next         = st_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        slot_valid_next = slot_valid_reg;
        ram_we          = 1'b0;

        // Slot walk shared by check and add: one read issued per cycle.
        if ((state_reg == S_CHECK || state_reg == S_ADD) && issue)
        begin
            idx_next     = idx_inc;
            k_next       = k_reg + 1'b1;
            wr_idx_next  = idx_reg;
            vbit_next    = slot_valid_reg[idx_reg];
            rd_pend_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                acc_next = 1'b1;
                st_next  = ST_OK;
                if (req_reg.req_type == REQ_ADVANCE && req_reg.new_time < cur_time_reg)
                begin
                    acc_next   = 1'b0;
                    st_next    = ST_BACKWARD;
                    state_next = S_DONE;
                end
                else if ((req_reg.req_type == REQ_CHECK || req_reg.req_type == REQ_RESERVE) &&
                         len_sum > 9'(SLOTS))
                begin
                    acc_next   = 1'b0;
                    st_next    = ST_TOO_LONG;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV0;
                end
            end
            S_DIV0:
            begin
                if (div_done)
                begin
                    q0_next    = div_quo;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                // The ring position is the first slot number modulo SLOTS.
                if (div_done)
                begin
                    q1_next    = div_quo;
                    base_next  = q0_reg[IDX_W-1:0];
                    idx_next   = q0_reg[IDX_W-1:0];
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                k_next    = '0;
                fail_next = 1'b0;
                if (req_reg.req_type == REQ_ADVANCE)
                begin
                    cur_time_next = req_reg.new_time;
                    if (span >= DIV_W'(SLOTS))
                    begin
                        slot_valid_next = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cnt_next   = span[CNT_W-1:0];
                        state_next = S_CLEAR;
                    end
                end
                else
                begin
                    cnt_next   = (span > DIV_W'(SLOTS)) ? CNT_W'(SLOTS) : span[CNT_W-1:0];
                    state_next = (req_reg.req_type == REQ_FORCE) ? S_ADD : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (rd_pend_reg && sum > {1'b0, capacity_reg})
                begin
                    fail_next = 1'b1;
                end
                if (!issue && !rd_pend_reg)
                begin
                    if (fail_reg)
                    begin
                        acc_next   = 1'b0;
                        st_next    = ST_OVER_CAP;
                        state_next = S_DONE;
                    end
                    else if (req_reg.req_type == REQ_RESERVE)
                    begin
                        k_next     = '0;
                        idx_next   = base_reg;
                        state_next = S_ADD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ADD:
            begin
                if (rd_pend_reg)
                begin
                    ram_we                      = 1'b1;
                    slot_valid_next[wr_idx_reg] = 1'b1;
                end
                if (!issue && !rd_pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                if (issue)
                begin
                    slot_valid_next[idx_reg] = 1'b0;
                    idx_next                 = idx_inc;
                    k_next                   = k_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.accepted = acc_reg;
                    out_data_next.status   = st_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_time_reg   <= '0;
            capacity_reg   <= '1;
            scale_reg      <= SCALE_W'(1);
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_time_reg   <= cur_time_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
            slot_valid_reg <= slot_valid_next;
            if (cfg_we && cfg_index == REG_CAPACITY)
            begin
                capacity_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_SCALE)
            begin
                scale_reg <= cfg_data[SCALE_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        q0_reg       <= q0_next;
        q1_reg       <= q1_next;
        base_reg     <= base_next;
        idx_reg      <= idx_next;
        wr_idx_reg   <= wr_idx_next;
        cnt_reg      <= cnt_next;
        k_reg        <= k_next;
        vbit_reg     <= vbit_next;
        fail_reg     <= fail_next;
        acc_reg      <= acc_next;
        st_reg       <= st_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/core/slr_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module slr_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/slr_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module slr_div
    import slr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_W-1:0]   dividend,
    input  logic [SCALE_W-1:0] divisor,
    output logic               done,
    output logic [DIV_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [DIV_W-1:0]   quo_next;
    logic [SCALE_W-1:0] rem_reg;
    logic [SCALE_W-1:0] rem_next;
    logic [SCALE_W-1:0] dvs_reg;
    logic [SCALE_W:0]   shifted;
    logic [SCALE_W:0]   trial;
    logic               fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        trial    = shifted - {1'b0, dvs_reg};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? trial[SCALE_W-1:0] : shifted[SCALE_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/slr_checker.sv -----
// Port-level checker for the slotted bandwidth reservation block, with its bind.
module slr_checker
    import slr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input rsp_t out_data,
    input logic out_valid,
    input logic out_ready
);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    // A granted request always reports ok, and a refused one never does.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.accepted == (out_data.status == ST_OK)))
        else $error("accepted flag disagrees with status");

    // Only one request is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while busy");

    // A result is not shown in the cycle after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind slotted_bandwidth_reservation slr_checker u_slr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the slotted bandwidth reservation block.
module tb_top;
    import slr_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    req_t                 in_data;
    logic                 out_valid;
    logic                 out_ready;
    rsp_t                 out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    // Shadow copy of the calendar and its settings.
    logic [31:0] shadow_load [SLOTS];
    logic [31:0] shadow_now;
    logic [31:0] shadow_capacity;
    logic [15:0] shadow_scale;

    rsp_t        pending_rsp[$];
    int          error_count;
    int          rsp_count;
    int          word_count;
    int          reject_count;
    longint      cycle_count;
    bit          stall_enable;

    slotted_bandwidth_reservation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Guard against a hung block.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 4000000)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("FAIL slotted_bandwidth_reservation");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("Mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Short gaps most of the time, a long one now and then.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 300);
    endfunction

    // Compute the result of one request and update the shadow calendar.
    function automatic rsp_t predict_calendar(input req_t rq);
        rsp_t     r;
        longint   sc;
        longint   start_t;
        longint   end_t;
        longint   first_no;
        longint   last_no;
        longint   span;
        longint   old_no;
        longint   new_no;
        longint   sum;
        int       idx;
        r.accepted = 1'b1;
        r.status   = ST_OK;
        sc = (shadow_scale == 0) ? 1 : longint'(shadow_scale);
        if (rq.req_type == REQ_ADVANCE)
        begin
            if (rq.new_time < shadow_now)
            begin
                r.accepted = 1'b0;
                r.status   = ST_BACKWARD;
            end
            else
            begin
                old_no = longint'(shadow_now) / sc;
                new_no = longint'(rq.new_time) / sc;
                if (new_no - old_no >= SLOTS)
                begin
                    foreach (shadow_load[i])
                        shadow_load[i] = '0;
                end
                else
                begin
                    for (longint k = 0; k < new_no - old_no; k++)
                        shadow_load[(old_no + k) % SLOTS] = '0;
                end
                shadow_now = rq.new_time;
            end
            return r;
        end
        start_t  = longint'(shadow_now) + rq.start_offset;
        end_t    = start_t + rq.duration;
        first_no = start_t / sc;
        last_no  = (end_t + sc - 1) / sc;
        span     = last_no - first_no;
        if (span > SLOTS)
            span = SLOTS;
        if (rq.req_type != REQ_FORCE)
        begin
            if (int'(rq.start_offset) + int'(rq.duration) > SLOTS)
            begin
                r.accepted = 1'b0;
                r.status   = ST_TOO_LONG;
            end
            else
            begin
                for (longint k = 0; k < span; k++)
                begin
                    idx = int'((first_no + k) % SLOTS);
                    if (longint'(shadow_load[idx]) + longint'(rq.amount)
                        > longint'(shadow_capacity))
                    begin
                        r.accepted = 1'b0;
                        r.status   = ST_OVER_CAP;
                        break;
                    end
                end
            end
        end
        if (r.accepted && rq.req_type != REQ_CHECK)
        begin
            for (longint k = 0; k < span; k++)
            begin
                idx = int'((first_no + k) % SLOTS);
                sum = longint'(shadow_load[idx]) + longint'(rq.amount);
                shadow_load[idx] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end
        end
        return r;
    endfunction

    // Send one request word and record its expected result on acceptance.
    // Valid stays high after acceptance until the next gap or idle period drops it.
    task automatic send_word(input req_t rq);
        int gap;
        gap = stall_enable ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rq;
        do
            @(posedge clk);
        while (!in_ready);
        pending_rsp.push_back(predict_calendar(rq));
        word_count++;
    endtask

    // Check each result word against the oldest expectation.
    initial
    begin
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                rsp_count++;
                if (pending_rsp.size() == 0)
                    report_mismatch("result word with none expected");
                else
                begin
                    want = pending_rsp.pop_front();
                    if (out_data.accepted != want.accepted)
                        report_mismatch($sformatf("accepted got %0b want %0b",
                            out_data.accepted, want.accepted));
                    if (out_data.status != want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                            out_data.status, want.status));
                    if (!want.accepted)
                        reject_count++;
                end
            end
        end
    end

    // Receiver stalls.
    initial
    begin
        int gap;
        forever
        begin
            gap = stall_enable ? pick_gap() : 0;
            out_ready <= (gap == 0);
            repeat (gap == 0 ? 1 : gap) @(posedge clk);
        end
    end

    // Drop the input and wait until every result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // Registers are written only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_CAPACITY)
            shadow_capacity = val;
        else if (idx == REG_SCALE)
            shadow_scale = val[15:0];
    endtask

    function automatic req_t make_req(input logic [1:0] kind, input logic [7:0] so,
                                      input logic [7:0] du, input logic [31:0] amt,
                                      input logic [31:0] nt);
        req_t rq;
        rq.req_type     = kind;
        rq.start_offset = so;
        rq.duration     = du;
        rq.amount       = amt;
        rq.new_time     = nt;
        return rq;
    endfunction

    // Each kind of request and each corner case, at default settings first.
    task automatic test_directed();
        send_word(make_req(REQ_CHECK, 8'd0, 8'd0, 32'd5, 32'd0));
        send_word(make_req(REQ_RESERVE, 8'd0, 8'd10, 32'd100, 32'hFFFF_FFFF));
        send_word(make_req(REQ_RESERVE, 8'd100, 8'd29, 32'd1, 32'd0));
        send_word(make_req(REQ_CHECK, 8'd255, 8'd255, 32'd1, 32'd0));
        send_word(make_req(REQ_FORCE, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'd0));
        send_word(make_req(REQ_FORCE, 8'd0, 8'd4, 32'hFFFF_FFFF, 32'd0));
        send_word(make_req(REQ_CHECK, 8'd0, 8'd4, 32'd1, 32'd0));
        send_word(make_req(REQ_RESERVE, 8'd0, 8'd128, 32'd0, 32'd0));
        write_reg(REG_CAPACITY, 32'd100);
        send_word(make_req(REQ_RESERVE, 8'd10, 8'd5, 32'd100, 32'd0));
        send_word(make_req(REQ_RESERVE, 8'd12, 8'd1, 32'd1, 32'd0));
        send_word(make_req(REQ_ADVANCE, 8'd0, 8'd0, 32'd0, 32'd5));
        send_word(make_req(REQ_ADVANCE, 8'd0, 8'd0, 32'd0, 32'd4));
        send_word(make_req(REQ_ADVANCE, 8'd0, 8'd0, 32'd0, 32'd5));
        send_word(make_req(REQ_ADVANCE, 8'd0, 8'd0, 32'd0, 32'd500));
        write_reg(REG_SCALE, 32'd7);
        send_word(make_req(REQ_RESERVE, 8'd1, 8'd0, 32'd3, 32'd0));
        send_word(make_req(REQ_RESERVE, 8'd3, 8'd0, 32'd3, 32'd0));
        send_word(make_req(REQ_ADVANCE, 8'd0, 8'd0, 32'd0, 32'd502));
        write_reg(REG_SCALE, 32'd0);
        send_word(make_req(REQ_RESERVE, 8'd5, 8'd9, 32'd50, 32'd0));
        write_reg(REG_SCALE, 32'h0000_FFFF);
        send_word(make_req(REQ_RESERVE, 8'd0, 8'd128, 32'd20, 32'd0));
        send_word(make_req(REQ_ADVANCE, 8'd0, 8'd0, 32'd0, 32'hFFFF_FFFF));
        send_word(make_req(REQ_FORCE, 8'd255, 8'd255, 32'hAAAA_5555, 32'd0));
        write_reg(REG_CAPACITY, 32'hFFFF_FFFF);
        write_reg(2'd3, 32'd0);
        send_word(make_req(REQ_CHECK, 8'd1, 8'd1, 32'd1, 32'd0));
    endtask

    // Random requests in phases with different settings.
    task automatic test_random(input int n, input logic [15:0] scale,
                               input logic [31:0] cap);
        req_t        rq;
        int          roll;
        logic [31:0] step;
        write_reg(REG_SCALE, 32'(scale));
        write_reg(REG_CAPACITY, cap);
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            rq.req_type     = (roll < 30) ? REQ_CHECK : (roll < 65) ? REQ_RESERVE :
                              (roll < 80) ? REQ_FORCE : REQ_ADVANCE;
            rq.start_offset = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                              8'($urandom_range(0, 64));
            rq.duration     = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                              8'($urandom_range(0, 64));
            rq.amount       = ($urandom_range(0, 9) == 0) ? $urandom :
                              $urandom_range(0, 60);
            roll = $urandom_range(0, 99);
            step = (roll < 50) ? $urandom_range(0, 3 * scale + 3) :
                   (roll < 80) ? $urandom_range(0, 200 * scale + 200) : $urandom;
            if (roll >= 95)
                rq.new_time = $urandom;
            else if (shadow_now > 32'hFFFF_FFFF - step)
                rq.new_time = 32'hFFFF_FFFF;
            else
                rq.new_time = shadow_now + step;
            send_word(rq);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        error_count  = 0;
        rsp_count    = 0;
        word_count   = 0;
        reject_count = 0;
        stall_enable = 1'b0;
        foreach (shadow_load[i])
            shadow_load[i] = '0;
        shadow_now      = '0;
        shadow_capacity = 32'hFFFF_FFFF;
        shadow_scale    = 16'd1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        stall_enable = 1'b1;
        test_random(300, 16'd1, 32'd150);
        test_random(300, 16'd3, 32'd100);
        test_random(200, 16'd0, 32'd0);
        test_random(250, 16'd17, 32'hFFFF_FFFF);
        stall_enable = 1'b0;
        test_random(150, 16'hFFFF, 32'd80);
        wait_drained();
        repeat (400) @(posedge clk);

        $display("Covered %0d request words, %0d results, %0d refused, across six settings.",
                 word_count, rsp_count, reject_count);
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("PASS slotted_bandwidth_reservation");
        else
            $display("FAIL slotted_bandwidth_reservation");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/slr_pkg.sv
rtl/core/slr_ram.sv
rtl/core/slr_div.sv
rtl/core/slotted_bandwidth_reservation.sv
rtl/core/slr_checker.sv
dv/tb_top.sv
